// ----- rtl/rrd_pkg.sv -----
// Types and constants shared by the refraction direction unit
package rrd_pkg;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               is_outside;
    logic               air_boundary;
    logic [13:0]        origin_index;
    logic [13:0]        hit_index;
    logic [15:0]        transmit_coeff;
    logic [15:0]        contrib;
  } ray_in_t;

  typedef struct packed {
    logic signed [15:0] new_dir_x;
    logic signed [15:0] new_dir_y;
    logic signed [15:0] new_dir_z;
    logic [15:0]        new_contrib;
    logic               new_outside;
    logic               total_internal;
  } ray_out_t;

  // per-ray data carried alongside the arithmetic
  typedef struct packed {
    logic [2:0][15:0] dir;
    logic [2:0][15:0] nrm;
    logic             outside;
    logic [15:0]      cont;
  } ray_t;

  typedef struct packed {
    ray_t               ray;
    logic signed [33:0] ndot;
  } div_side_t;

  typedef struct packed {
    ray_t               ray;
    logic               tir;
    logic signed [29:0] c1;
    logic signed [31:0] w;
    logic [15:0]        eta;
  } sq_side_t;

  localparam int unsigned DIV_QW     = 16;
  localparam int unsigned DIV_NW     = 28;
  localparam int unsigned DIV_DW     = 14;
  localparam int unsigned DIV_STEP   = 4;
  localparam int unsigned DIV_STAGES = DIV_QW / DIV_STEP;

  localparam int unsigned SQ_W     = 62;
  localparam int unsigned SQ_STEPS = 31;

  localparam logic [15:0] ETA_MAX     = 16'hFFFF;
  localparam logic [15:0] CONTRIB_ONE = 16'h8000;
  localparam int          DIR_MAX     = 16384;

endpackage

// ----- rtl/rrd_div.sv -----
// Pipelined restoring divider for the index ratio, four quotient bits per stage
module rrd_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [27:0]         num_i,
  input  logic [13:0]         den_i,
  input  logic                force_i,
  input  logic [15:0]         fval_i,
  input  rrd_pkg::div_side_t  side_i,
  output logic                valid_o,
  output logic [15:0]         eta_o,
  output rrd_pkg::div_side_t  side_o
);

  localparam int unsigned QW = rrd_pkg::DIV_QW;
  localparam int unsigned NW = rrd_pkg::DIV_NW;
  localparam int unsigned DW = rrd_pkg::DIV_DW;
  localparam int unsigned SW = rrd_pkg::DIV_STEP;
  localparam int unsigned NS = rrd_pkg::DIV_STAGES;

  function automatic logic [DW+SW-1:0] div_step(input logic [DW-1:0] rem,
                                                input logic [SW-1:0] bits,
                                                input logic [DW-1:0] den);
    logic [DW:0]   t;
    logic [DW-1:0] r;
    logic [SW-1:0] q;
    r = rem;
    q = '0;
    for (int i = SW - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, den}) begin
        t    = t - {1'b0, den};
        q[i] = 1'b1;
      end
      r = t[DW-1:0];
    end
    return {r, q};
  endfunction

  logic [NS-1:0]      vld_q;
  logic [DW-1:0]      rem_q  [NS];
  logic [QW-1:0]      quo_q  [NS];
  logic [QW-1:0]      lo_q   [NS];
  logic [DW-1:0]      den_q  [NS];
  logic               frc_q  [NS];
  logic [15:0]        fval_q [NS];
  rrd_pkg::div_side_t side_q [NS];

  logic [NS-1:0]      vld_in;
  logic [DW-1:0]      rem_in  [NS];
  logic [QW-1:0]      quo_in  [NS];
  logic [QW-1:0]      lo_in   [NS];
  logic [DW-1:0]      den_in  [NS];
  logic               frc_in  [NS];
  logic [15:0]        fval_in [NS];
  rrd_pkg::div_side_t side_in [NS];
  logic [DW+SW-1:0]   res     [NS];

  always_comb begin
    vld_in[0]  = valid_i;
    rem_in[0]  = {{(DW-(NW-QW)){1'b0}}, num_i[NW-1:QW]};
    quo_in[0]  = '0;
    lo_in[0]   = num_i[QW-1:0];
    den_in[0]  = den_i;
    frc_in[0]  = force_i;
    fval_in[0] = fval_i;
    side_in[0] = side_i;
    for (int k = 1; k < NS; k++) begin
      vld_in[k]  = vld_q[k-1];
      rem_in[k]  = rem_q[k-1];
      quo_in[k]  = quo_q[k-1];
      lo_in[k]   = lo_q[k-1];
      den_in[k]  = den_q[k-1];
      frc_in[k]  = frc_q[k-1];
      fval_in[k] = fval_q[k-1];
      side_in[k] = side_q[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      res[k] = div_step(rem_in[k], lo_in[k][QW-1 -: SW], den_in[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        rem_q[k]  <= res[k][DW+SW-1:SW];
        quo_q[k]  <= {quo_in[k][QW-SW-1:0], res[k][SW-1:0]};
        lo_q[k]   <= {lo_in[k][QW-SW-1:0], {SW{1'b0}}};
        den_q[k]  <= den_in[k];
        frc_q[k]  <= frc_in[k];
        fval_q[k] <= fval_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign eta_o   = frc_q[NS-1] ? fval_q[NS-1] : quo_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

// ----- rtl/rrd_sqrt.sv -----
// Pipelined bit-pair square root, one result bit per stage, rounded to nearest
module rrd_sqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [rrd_pkg::SQ_W-1:0] x_i,
  input  rrd_pkg::sq_side_t        side_i,
  output logic                     valid_o,
  output logic [31:0]              root_o,
  output rrd_pkg::sq_side_t        side_o
);

  localparam int unsigned W  = rrd_pkg::SQ_W;
  localparam int unsigned NS = rrd_pkg::SQ_STEPS;

  logic [NS-1:0]     vld_q;
  logic [W-1:0]      v_q    [NS];
  logic [W-1:0]      r_q    [NS];
  rrd_pkg::sq_side_t side_q [NS];

  logic [NS-1:0]     vld_in;
  logic [W-1:0]      v_in    [NS];
  logic [W-1:0]      r_in    [NS];
  rrd_pkg::sq_side_t side_in [NS];
  logic [W-1:0]      v_nx    [NS];
  logic [W-1:0]      r_nx    [NS];

  logic              fv_q;
  logic [31:0]       root_q;
  rrd_pkg::sq_side_t fside_q;

  always_comb begin
    logic [W-1:0] bitv;
    logic [W-1:0] t;
    vld_in[0]  = valid_i;
    v_in[0]    = x_i;
    r_in[0]    = '0;
    side_in[0] = side_i;
    for (int k = 1; k < NS; k++) begin
      vld_in[k]  = vld_q[k-1];
      v_in[k]    = v_q[k-1];
      r_in[k]    = r_q[k-1];
      side_in[k] = side_q[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      bitv = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * k);
      t    = r_in[k] + bitv;
      if (v_in[k] >= t) begin
        v_nx[k] = v_in[k] - t;
        r_nx[k] = (r_in[k] >> 1) + bitv;
      end else begin
        v_nx[k] = v_in[k];
        r_nx[k] = r_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      fv_q  <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_in;
      fv_q  <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        v_q[k]    <= v_nx[k];
        r_q[k]    <= r_nx[k];
        side_q[k] <= side_in[k];
      end
      root_q  <= r_q[NS-1][31:0] + {31'b0, (v_q[NS-1] > r_q[NS-1])};
      fside_q <= side_q[NS-1];
    end
  end

  assign valid_o = fv_q;
  assign root_o  = root_q;
  assign side_o  = fside_q;

endmodule

// ----- rtl/ray_refraction_direction_unit.sv -----
// Top level: refraction of a ray direction with total internal reflection fallback
// Throughput: one request per cycle; the whole pipeline advances when the output
// register is empty or being taken, so a stall holds every stage in place.
// Depth is set by the 4-stage index divider and the 32-stage square root.
// Reset clears all stage valid bits; no other state.
module ray_refraction_direction_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rrd_pkg::ray_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rrd_pkg::ray_out_t out_o
);

  localparam logic [27:0] NUM_AIR = 28'd67108864;

  function automatic logic signed [15:0] sat_dir(input logic signed [26:0] v);
    logic signed [15:0] r;
    if (v > 27'sd16384) begin
      r = 16'(rrd_pkg::DIR_MAX);
    end else if (v < -27'sd16384) begin
      r = -16'(rrd_pkg::DIR_MAX);
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic en;
  logic s12_v_q;
  assign en         = !s12_v_q || out_ready_i;
  assign in_ready_o = en;

  // S1: dot products, contribution product, divider set-up
  logic               s1_v_q;
  logic signed [31:0] s1_p_q [3];
  logic [31:0]        s1_cp_q;
  logic [27:0]        s1_num_q;
  logic [13:0]        s1_den_q;
  logic               s1_frc_q;
  logic [15:0]        s1_fval_q;
  rrd_pkg::ray_t      s1_ray_q;

  logic [27:0] num_d;
  logic        sat_d;
  logic        into_air;
  always_comb begin
    into_air = !in_i.is_outside && in_i.air_boundary;
    num_d    = ((in_i.is_outside && in_i.air_boundary) ? NUM_AIR
                : {in_i.origin_index, 14'b0}) + {15'b0, in_i.hit_index[13:1]};
    sat_d    = {2'b0, num_d} >= {in_i.hit_index, 16'b0};
  end

  // S2: dot sum, contribution rounding
  logic               s2_v_q;
  logic signed [33:0] s2_ndot_q;
  logic [27:0]        s2_num_q;
  logic [13:0]        s2_den_q;
  logic               s2_frc_q;
  logic [15:0]        s2_fval_q;
  rrd_pkg::ray_t      s2_ray_q;

  logic [32:0]   cr_sum;
  logic [17:0]   cr;
  logic [15:0]   cont_d;
  rrd_pkg::ray_t ray2_d;
  always_comb begin
    cr_sum      = {1'b0, s1_cp_q} + 33'd16384;
    cr          = cr_sum[32:15];
    cont_d      = (cr > 18'd32768) ? rrd_pkg::CONTRIB_ONE : cr[15:0];
    ray2_d      = s1_ray_q;
    ray2_d.cont = cont_d;
  end

  rrd_pkg::div_side_t dv_side_in;
  rrd_pkg::div_side_t dv_side;
  logic               dv_v;
  logic [15:0]        dv_eta;
  always_comb begin
    dv_side_in.ray  = s2_ray_q;
    dv_side_in.ndot = s2_ndot_q;
  end

  rrd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_v_q),
    .num_i   (s2_num_q),
    .den_i   (s2_den_q),
    .force_i (s2_frc_q),
    .fval_i  (s2_fval_q),
    .side_i  (dv_side_in),
    .valid_o (dv_v),
    .eta_o   (dv_eta),
    .side_o  (dv_side)
  );

  // S3..S8: c1, w, c2
  logic               s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q, s8_v_q;
  logic signed [29:0] s3_c1_q, s4_c1_q, s5_c1_q, s6_c1_q, s7_c1_q;
  logic [15:0]        s3_eta_q, s4_eta_q, s5_eta_q, s6_eta_q, s7_eta_q;
  rrd_pkg::ray_t      s3_ray_q, s4_ray_q, s5_ray_q, s6_ray_q, s7_ray_q;
  logic signed [46:0] s4_weta_q;
  logic signed [31:0] s5_w_q, s6_w_q, s7_w_q;
  logic signed [31:0] s6_a_q, s6_b_q;
  logic signed [63:0] s7_prod_q;
  logic [rrd_pkg::SQ_W-1:0] s8_x_q;
  rrd_pkg::sq_side_t  s8_side_q;

  logic signed [33:0] c1_sum;
  logic signed [46:0] w_sum;
  logic signed [63:0] c2_sum;
  logic signed [31:0] eta24;
  always_comb begin
    c1_sum = dv_side.ndot + (dv_side.ndot[33] ? 34'sd7 : 34'sd8);
    w_sum  = s4_weta_q + (s4_weta_q[46] ? 47'sd8191 : 47'sd8192);
    eta24  = $signed({6'b0, s5_eta_q, 10'b0});
    c2_sum = s7_prod_q + (s7_prod_q[63] ? 64'sd8388607 : 64'sd8388608)
             + 64'sd281474976710656;
  end

  // sqrt
  logic              sq_v;
  logic [31:0]       sq_root;
  rrd_pkg::sq_side_t sq_side;

  rrd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s8_v_q),
    .x_i     (s8_x_q),
    .side_i  (s8_side_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // S9..S12: scale, products, sum, round and saturate
  logic               s9_v_q, s10_v_q, s11_v_q;
  logic signed [33:0] s9_scale_q;
  logic [26:0]        s9_coef_q;
  logic               s9_tir_q, s10_tir_q, s11_tir_q;
  rrd_pkg::ray_t      s9_ray_q, s10_ray_q, s11_ray_q;
  logic signed [49:0] s10_m_q [3];
  logic signed [43:0] s10_e_q [3];
  logic signed [50:0] s11_t_q [3];
  rrd_pkg::ray_out_t  s12_out_q;

  logic signed [50:0] rt    [3];
  logic signed [15:0] dir_d [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rt[i]    = s11_t_q[i] + (s11_t_q[i][50] ? 51'sd8388607 : 51'sd8388608);
      dir_d[i] = sat_dir(rt[i][50:24]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      s6_v_q  <= 1'b0;
      s7_v_q  <= 1'b0;
      s8_v_q  <= 1'b0;
      s9_v_q  <= 1'b0;
      s10_v_q <= 1'b0;
      s11_v_q <= 1'b0;
      s12_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= in_valid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= dv_v;
      s4_v_q  <= s3_v_q;
      s5_v_q  <= s4_v_q;
      s6_v_q  <= s5_v_q;
      s7_v_q  <= s6_v_q;
      s8_v_q  <= s7_v_q;
      s9_v_q  <= sq_v;
      s10_v_q <= s9_v_q;
      s11_v_q <= s10_v_q;
      s12_v_q <= s11_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_p_q[0]        <= in_i.dir_x * in_i.normal_x;
      s1_p_q[1]        <= in_i.dir_y * in_i.normal_y;
      s1_p_q[2]        <= in_i.dir_z * in_i.normal_z;
      s1_cp_q          <= in_i.transmit_coeff * in_i.contrib;
      s1_num_q         <= num_d;
      s1_den_q         <= in_i.hit_index;
      s1_frc_q         <= into_air || sat_d;
      s1_fval_q        <= into_air ? {in_i.hit_index, 2'b00} : rrd_pkg::ETA_MAX;
      s1_ray_q.dir     <= {in_i.dir_z, in_i.dir_y, in_i.dir_x};
      s1_ray_q.nrm     <= {in_i.normal_z, in_i.normal_y, in_i.normal_x};
      s1_ray_q.outside <= in_i.is_outside;
      s1_ray_q.cont    <= '0;

      s2_ndot_q     <= 34'sd0 - (34'(s1_p_q[0]) + 34'(s1_p_q[1]) + 34'(s1_p_q[2]));
      s2_num_q      <= s1_num_q;
      s2_den_q      <= s1_den_q;
      s2_frc_q      <= s1_frc_q;
      s2_fval_q     <= s1_fval_q;
      s2_ray_q      <= ray2_d;

      s3_c1_q  <= c1_sum[33:4];
      s3_eta_q <= dv_eta;
      s3_ray_q <= dv_side.ray;

      s4_weta_q <= $signed({1'b0, s3_eta_q}) * s3_c1_q;
      s4_c1_q   <= s3_c1_q;
      s4_eta_q  <= s3_eta_q;
      s4_ray_q  <= s3_ray_q;

      s5_w_q   <= w_sum[45:14];
      s5_c1_q  <= s4_c1_q;
      s5_eta_q <= s4_eta_q;
      s5_ray_q <= s4_ray_q;

      s6_a_q   <= s5_w_q - eta24;
      s6_b_q   <= s5_w_q + eta24;
      s6_w_q   <= s5_w_q;
      s6_c1_q  <= s5_c1_q;
      s6_eta_q <= s5_eta_q;
      s6_ray_q <= s5_ray_q;

      s7_prod_q <= 64'(s6_a_q) * 64'(s6_b_q);
      s7_w_q    <= s6_w_q;
      s7_c1_q   <= s6_c1_q;
      s7_eta_q  <= s6_eta_q;
      s7_ray_q  <= s6_ray_q;

      s8_x_q        <= c2_sum[63] ? '0 : {1'b0, c2_sum[60:24], 24'b0};
      s8_side_q.ray <= s7_ray_q;
      s8_side_q.tir <= c2_sum[63];
      s8_side_q.c1  <= s7_c1_q;
      s8_side_q.w   <= s7_w_q;
      s8_side_q.eta <= s7_eta_q;

      s9_scale_q <= sq_side.tir ? (34'(sq_side.c1) <<< 1)
                    : (34'(sq_side.w) - $signed({2'b0, sq_root}));
      s9_coef_q  <= sq_side.tir ? 27'd16777216 : {1'b0, sq_side.eta, 10'b0};
      s9_tir_q   <= sq_side.tir;
      s9_ray_q   <= sq_side.ray;

      for (int i = 0; i < 3; i++) begin
        s10_m_q[i] <= 50'(s9_scale_q) * 50'($signed(s9_ray_q.nrm[i]));
        s10_e_q[i] <= 44'($signed({1'b0, s9_coef_q})) * 44'($signed(s9_ray_q.dir[i]));
        s11_t_q[i] <= 51'(s10_m_q[i]) + 51'(s10_e_q[i]);
      end
      s10_tir_q <= s9_tir_q;
      s10_ray_q <= s9_ray_q;
      s11_tir_q <= s10_tir_q;
      s11_ray_q <= s10_ray_q;

      s12_out_q.new_dir_x      <= dir_d[0];
      s12_out_q.new_dir_y      <= dir_d[1];
      s12_out_q.new_dir_z      <= dir_d[2];
      s12_out_q.new_contrib    <= s11_tir_q ? rrd_pkg::CONTRIB_ONE : s11_ray_q.cont;
      s12_out_q.new_outside    <= s11_tir_q ? s11_ray_q.outside : !s11_ray_q.outside;
      s12_out_q.total_internal <= s11_tir_q;
    end
  end

  assign out_valid_o = s12_v_q;
  assign out_o       = s12_out_q;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the ray refraction direction unit
module testbench;

  localparam int LATENCY   = 48;
  localparam int WDOG_MAX  = 20000;
  localparam int IN_W      = $bits(rrd_pkg::ray_in_t);

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  rrd_pkg::ray_in_t  in_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  rrd_pkg::ray_out_t out_o;

  rrd_pkg::ray_out_t expected_rays[$];
  int       mismatches = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  bit       hold_off = 1'b0;
  int       quiet_cycles = 0;

  ray_refraction_direction_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .in_i(in_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint round_shift(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v < 0) return -((-v + half) >>> s);
    return (v + half) >>> s;
  endfunction

  function automatic longint div_eta(longint num, longint den);
    longint q;
    if (den == 0) return 65535;
    q = (num + den / 2) / den;
    return (q > 65535) ? 65535 : q;
  endfunction

  function automatic longint root_round(longint x);
    longint r, lo, hi, mid;
    lo = 0;
    hi = 64'd3037000499;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= x) lo = mid;
      else hi = mid - 1;
    end
    r = lo;
    if (x - r * r > r) r++;
    return r;
  endfunction

  function automatic logic [15:0] clamp_dir(longint v);
    if (v > rrd_pkg::DIR_MAX) v = rrd_pkg::DIR_MAX;
    if (v < -rrd_pkg::DIR_MAX) v = -rrd_pkg::DIR_MAX;
    return v[15:0];
  endfunction

  function automatic rrd_pkg::ray_out_t refract_ray(rrd_pkg::ray_in_t r);
    rrd_pkg::ray_out_t o;
    longint d[3], n[3];
    longint eta, dot, c1, eta24, w, c2, s, sc, t, prod;
    d[0] = longint'(r.dir_x); d[1] = longint'(r.dir_y); d[2] = longint'(r.dir_z);
    n[0] = longint'(r.normal_x); n[1] = longint'(r.normal_y); n[2] = longint'(r.normal_z);
    if (r.is_outside && r.air_boundary)
      eta = div_eta(longint'(1) << 26, longint'(r.hit_index));
    else if (!r.is_outside && r.air_boundary) eta = longint'(r.hit_index) * 4;
    else eta = div_eta(longint'(r.origin_index) << 14, longint'(r.hit_index));
    dot = 0;
    for (int i = 0; i < 3; i++) dot += n[i] * d[i];
    c1 = round_shift(-dot, 4);
    eta24 = eta << 10;
    w = round_shift(eta * c1, 14);
    c2 = (longint'(1) << 24) + round_shift((w - eta24) * (w + eta24), 24);
    o = '0;
    if (c2 >= 0) begin
      s = root_round(c2 << 24);
      sc = w - s;
      for (int i = 0; i < 3; i++) begin
        t = eta24 * d[i] + sc * n[i];
        o[18 + 16 * (2 - i) +: 16] = clamp_dir(round_shift(t, 24));
      end
      prod = (longint'(r.transmit_coeff) * longint'(r.contrib) + longint'(1 << 14)) >>> 15;
      o.new_contrib = (prod > 32768) ? rrd_pkg::CONTRIB_ONE : prod[15:0];
      o.new_outside = !r.is_outside;
      o.total_internal = 1'b0;
    end else begin
      sc = 2 * c1;
      for (int i = 0; i < 3; i++) begin
        t = sc * n[i] + (d[i] << 24);
        o[18 + 16 * (2 - i) +: 16] = clamp_dir(round_shift(t, 24));
      end
      o.new_contrib = rrd_pkg::CONTRIB_ONE;
      o.new_outside = r.is_outside;
      o.total_internal = 1'b1;
    end
    return o;
  endfunction

  // valid stays high after acceptance until the next request or an idle cycle replaces it
  task automatic send_request(rrd_pkg::ray_in_t r);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= r;
    expected_rays.push_back(refract_ray(r));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // receiver and checker
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_rays.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_o);
      end else begin
        rrd_pkg::ray_out_t e;
        e = expected_rays.pop_front();
        if (e !== out_o) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h actual %h", e, out_o);
        end
      end
    end
    out_ready_i <= !hold_off && !(stall_pct > 0 && $urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic rrd_pkg::ray_in_t rand_ray();
    rrd_pkg::ray_in_t r;
    longint x, y, z, m;
    x = longint'($urandom_range(32768)) - 16384;
    y = longint'($urandom_range(32768)) - 16384;
    z = longint'($urandom_range(32768)) - 16384;
    m = root_round(x * x + y * y + z * z);
    if (m == 0) m = 1;
    r.dir_x = 16'(x * 16384 / m); r.dir_y = 16'(y * 16384 / m); r.dir_z = 16'(z * 16384 / m);
    x = longint'($urandom_range(32768)) - 16384;
    y = longint'($urandom_range(32768)) - 16384;
    z = longint'($urandom_range(32768)) - 16384;
    m = root_round(x * x + y * y + z * z);
    if (m == 0) m = 1;
    r.normal_x = 16'(x * 16384 / m);
    r.normal_y = 16'(y * 16384 / m);
    r.normal_z = 16'(z * 16384 / m);
    r.is_outside = 1'($urandom_range(1));
    r.air_boundary = 1'($urandom_range(1));
    r.origin_index = 14'($urandom_range(16383, 4096));
    r.hit_index = 14'($urandom_range(16383, 4096));
    r.transmit_coeff = 16'($urandom_range(32768));
    r.contrib = 16'($urandom_range(32768));
    if ($urandom_range(9) == 0) begin
      r = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
      r.transmit_coeff = 16'($urandom);
      r.contrib = 16'($urandom);
    end
    return r;
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_rays.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    rrd_pkg::ray_in_t r;
    r = '0;
    r.dir_z = -16'sd16384; r.normal_z = 16'sd16384;
    r.origin_index = 14'd4096; r.hit_index = 14'd6144;
    r.transmit_coeff = 16'd32768; r.contrib = 16'd32768;
    for (int k = 0; k < 4; k++) begin
      r.is_outside = k[0]; r.air_boundary = k[1];
      send_request(r);
    end
    r.hit_index = 14'd0; r.air_boundary = 1'b1; r.is_outside = 1'b1; send_request(r);
    r.air_boundary = 1'b0; send_request(r);
    r.hit_index = 14'd16383; r.origin_index = 14'd16383; send_request(r);
    r.hit_index = 14'd1; r.origin_index = 14'd16383; send_request(r);
    r.hit_index = 14'd4096; r.origin_index = 14'd16383;
    r.dir_x = 16'sd14000; r.dir_z = -16'sd8000;
    send_request(r);
    r.is_outside = 1'b0; r.air_boundary = 1'b1; r.hit_index = 14'd16383; send_request(r);
    r.dir_x = 16'sh7FFF; r.dir_y = 16'sh8000; r.dir_z = 16'sh7FFF;
    r.normal_x = 16'sh8000; r.normal_y = 16'sh7FFF; r.normal_z = 16'sh8000;
    send_request(r);
    r.transmit_coeff = 16'hFFFF; r.contrib = 16'hFFFF; r.air_boundary = 1'b0;
    r.hit_index = 14'h3FFF; r.origin_index = 14'h3FFF; send_request(r);
    r.dir_x = 16'sd16384; r.dir_y = 16'sd0; r.dir_z = 16'sd0;
    r.normal_x = -16'sd16384; r.normal_y = 16'sd0; r.normal_z = 16'sd0;
    r.transmit_coeff = 16'd0; r.contrib = 16'd0; send_request(r);
    r.dir_x = -16'sd16384; r.normal_x = 16'sd16384; r.hit_index = 14'd4096; send_request(r);
    drain();
  endtask

  task automatic test_random_phase(int count, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_request(rand_ray());
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (150) send_request(rand_ray());
    join
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(400, 0, 0);
    test_random_phase(350, 64, 0);
    test_random_phase(350, 0, 64);
    test_random_phase(350, 8, 8);
    test_backpressure();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0 && expected_rays.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
